// ===== rtl/rnd_pkg.sv =====
// Shared types, codes and digit tables of the Roman numeral decoder.
package rnd_pkg;

   // Class of one input character as seen by the decode engine.
   typedef enum logic [1:0] {
      KIND_DIGIT = 2'd0,
      KIND_BLANK = 2'd1,
      KIND_OTHER = 2'd2,
      KIND_EOS   = 2'd3
   } kind_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_ROMAN = 2'd1,
      STATUS_BAD_PAIR  = 2'd2,
      STATUS_OVERFLOW  = 2'd3
   } status_type;

   // Digit ranks, highest digit first.
   localparam logic [2:0] RANK_M = 3'd0;
   localparam logic [2:0] RANK_D = 3'd1;
   localparam logic [2:0] RANK_C = 3'd2;
   localparam logic [2:0] RANK_L = 3'd3;
   localparam logic [2:0] RANK_X = 3'd4;
   localparam logic [2:0] RANK_V = 3'd5;
   localparam logic [2:0] RANK_I = 3'd6;

   localparam int ADDEND_BITS = 10;
   localparam int RESULT_BITS = 16;

   // One classified character travelling from the front end to the decode engine.
   typedef struct packed {
      kind_type   kind;
      logic [2:0] rank;
   } item_type;

   function automatic logic [ADDEND_BITS-1:0] digit_weight(input logic [2:0] rank);
      logic [ADDEND_BITS-1:0] w;
      case (rank)
         RANK_M:  w = 10'd1000;
         RANK_D:  w = 10'd500;
         RANK_C:  w = 10'd100;
         RANK_L:  w = 10'd50;
         RANK_X:  w = 10'd10;
         RANK_V:  w = 10'd5;
         RANK_I:  w = 10'd1;
         default: w = 10'd0;
      endcase
      return w;
   endfunction

   // Value of a subtractive pair whose lower digit has rank low_rank.
   // two_up selects the form two ranks higher (900/90/9) over one rank (400/40/4).
   function automatic logic [ADDEND_BITS-1:0] pair_value(input logic [2:0] low_rank,
                                                         input logic       two_up);
      logic [ADDEND_BITS-1:0] v;
      case (low_rank)
         RANK_C:  v = two_up ? 10'd900 : 10'd400;
         RANK_X:  v = two_up ? 10'd90  : 10'd40;
         RANK_I:  v = two_up ? 10'd9   : 10'd4;
         default: v = 10'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/rnd_front.sv =====
// Front end: classifies each incoming character into digit, blank, other or end of stream.
module rnd_front
   import rnd_pkg::*;
(
   input  logic [7:0] character,
   input  logic       end_of_stream,
   output item_type   item
);

   logic       is_digit;
   logic [2:0] rank;
   logic       is_blank;

   always_comb begin
      is_digit = 1'b1;
      rank     = RANK_M;
      case (character)
         "M":     rank = RANK_M;
         "D":     rank = RANK_D;
         "C":     rank = RANK_C;
         "L":     rank = RANK_L;
         "X":     rank = RANK_X;
         "V":     rank = RANK_V;
         "I":     rank = RANK_I;
         default: is_digit = 1'b0;
      endcase
   end

   // Space, tab, newline, vertical tab, form feed and carriage return.
   assign is_blank = (character == 8'h20) || (character inside {[8'd9:8'd13]});

   always_comb begin
      item.rank = rank;
      if (end_of_stream) begin
         item.kind = KIND_EOS;
      end else if (is_digit) begin
         item.kind = KIND_DIGIT;
      end else if (is_blank) begin
         item.kind = KIND_BLANK;
      end else begin
         item.kind = KIND_OTHER;
      end
   end

endmodule

// ===== rtl/rnd_queue.sv =====
// Two-entry queue between the front end and the decode engine.
module rnd_queue
   import rnd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;
   logic       pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ===== rtl/rnd_back.sv =====
// Decode engine: keeps the number state, accumulates digit values and registers the results.
module rnd_back
   import rnd_pkg::*;
#(
   parameter int VALUE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   output logic                   item_ready,
   input  item_type               item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [RESULT_BITS-1:0] rsp_value,
   output status_type             rsp_status,
   output logic                   rsp_last
);

   logic [2:0]            pending_digit_ff, pending_digit_in;
   logic                  pending_valid_ff, pending_valid_in;
   logic [VALUE_BITS-1:0] sum_ff, sum_in;
   logic                  in_number_ff, in_number_in;
   logic                  pair_error_ff, pair_error_in;
   logic                  overflow_ff, overflow_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RESULT_BITS-1:0] rsp_value_ff, rsp_value_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [ADDEND_BITS-1:0] addend;
   logic [VALUE_BITS:0]    add_sum;
   logic                   add_ovf;
   logic [VALUE_BITS-1:0]  sat_sum;
   logic [VALUE_BITS-1:0]  emit_sum;
   logic [RESULT_BITS-1:0] emit_sum16;
   logic [2:0]             rank_gap;
   logic                   pair_ok;
   logic                   can_emit;
   logic                   need_emit;
   logic                   advance;
   logic                   pop;

   // A pair is legal when the higher digit sits one or two ranks above C, X or I.
   assign rank_gap = pending_digit_ff - item.rank;
   assign pair_ok  = ((rank_gap == 3'd1) || (rank_gap == 3'd2)) &&
                     (pending_digit_ff inside {RANK_C, RANK_X, RANK_I});

   always_comb begin
      addend = '0;
      if (in_number_ff && !pair_error_ff && pending_valid_ff) begin
         if (item.kind != KIND_DIGIT || item.rank >= pending_digit_ff) begin
            addend = digit_weight(pending_digit_ff);
         end else if (pair_ok) begin
            addend = pair_value(pending_digit_ff, rank_gap == 3'd2);
         end
      end
   end

   assign add_sum = {1'b0, sum_ff} + {{(VALUE_BITS + 1 - ADDEND_BITS){1'b0}}, addend};
   assign add_ovf = add_sum[VALUE_BITS];
   assign sat_sum = add_ovf ? {VALUE_BITS{1'b1}} : add_sum[VALUE_BITS-1:0];

   assign emit_sum = pair_error_ff ? '0 : sat_sum;
   generate
      if (VALUE_BITS >= RESULT_BITS) begin : g_trunc
         assign emit_sum16 = emit_sum[RESULT_BITS-1:0];
      end else begin : g_extend
         assign emit_sum16 = {{(RESULT_BITS - VALUE_BITS){1'b0}}, emit_sum};
      end
   endgenerate

   // Any terminator inside a number emits it; an unknown character then also
   // emits not_roman, so its item stays in the queue until that result is emitted.
   assign need_emit  = (item.kind != KIND_DIGIT) && (in_number_ff || item.kind == KIND_OTHER);
   assign can_emit   = !rsp_valid_ff || rsp_ready;
   assign advance    = item_valid && (!need_emit || can_emit);
   assign pop        = advance && !(in_number_ff && item.kind == KIND_OTHER);
   assign item_ready = pop;

   always_comb begin
      pending_digit_in = pending_digit_ff;
      pending_valid_in = pending_valid_ff;
      sum_in           = sum_ff;
      in_number_in     = in_number_ff;
      pair_error_in    = pair_error_ff;
      overflow_in      = overflow_ff;
      rsp_value_in     = rsp_value_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_valid_in     = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (advance) begin
         if (item.kind == KIND_DIGIT) begin
            if (!in_number_ff) begin
               in_number_in     = 1'b1;
               pending_digit_in = item.rank;
               pending_valid_in = 1'b1;
               sum_in           = '0;
               pair_error_in    = 1'b0;
               overflow_in      = 1'b0;
            end else if (!pair_error_ff) begin
               sum_in      = sat_sum;
               overflow_in = overflow_ff || add_ovf;
               if (!pending_valid_ff || item.rank >= pending_digit_ff) begin
                  pending_digit_in = item.rank;
                  pending_valid_in = 1'b1;
               end else begin
                  pending_valid_in = 1'b0;
                  pair_error_in    = !pair_ok;
               end
            end
         end else if (in_number_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = emit_sum16;
            rsp_last_in   = (item.kind != KIND_OTHER);
            if (pair_error_ff) begin
               rsp_status_in = STATUS_BAD_PAIR;
            end else if (overflow_ff || add_ovf) begin
               rsp_status_in = STATUS_OVERFLOW;
            end else begin
               rsp_status_in = STATUS_OK;
            end
            pending_digit_in = RANK_M;
            pending_valid_in = 1'b0;
            sum_in           = '0;
            in_number_in     = 1'b0;
            pair_error_in    = 1'b0;
            overflow_in      = 1'b0;
         end else if (item.kind == KIND_OTHER) begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = '0;
            rsp_status_in = STATUS_NOT_ROMAN;
            rsp_last_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_digit_ff <= RANK_M;
         pending_valid_ff <= 1'b0;
         sum_ff           <= '0;
         in_number_ff     <= 1'b0;
         pair_error_ff    <= 1'b0;
         overflow_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         pending_digit_ff <= pending_digit_in;
         pending_valid_ff <= pending_valid_in;
         sum_ff           <= sum_in;
         in_number_ff     <= in_number_in;
         pair_error_ff    <= pair_error_in;
         overflow_ff      <= overflow_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

`ifndef ASSERT_OFF
   a_pending_in_number: assert property (@(posedge clock) disable iff (reset)
      pending_valid_ff |-> in_number_ff)
      else $error("pending digit held outside a number");

   a_not_roman_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_NOT_ROMAN) |-> (rsp_last_ff && rsp_value_ff == '0))
      else $error("not_roman result must be last and carry zero");

   a_split_item_held: assert property (@(posedge clock) disable iff (reset)
      (advance && !pop) |=> (item_valid && item.kind == KIND_OTHER && !in_number_ff))
      else $error("second result of an unknown character lost its item");

   a_bad_pair_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_BAD_PAIR) |-> (rsp_value_ff == '0))
      else $error("bad pair result must carry zero");
`endif

endmodule

// ===== rtl/roman_numeral_decoder_core.sv =====
// A beat that ends a number is written into the queue at its req handshake; the decode engine
// then reads it from the queue and registers its result in the output register that drives rsp.
// Throughput: one req beat per cycle while the queue has room; an unknown character that ends
// a number gives two results and holds the decode engine until both enter the single output register.
// Reset: synchronous and active high; it empties the queue and the output register and clears
// the number state. There is no clearing pass.
module roman_numeral_decoder_core
   import rnd_pkg::*;
#(
   parameter int VALUE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel. req_tdata: character [7:0]. req_tlast: end_of_stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   // Result channel. rsp_tdata: number_value [15:0]. rsp_tuser: status [1:0].
   // rsp_tlast: last_of_run, set on the final result caused by one req beat.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   // The front end classifies each character as it arrives. Classification is pure
   // lookup logic, so the beat lands in the queue in the cycle it is accepted.
   item_type   front_item;
   item_type   queue_item;
   logic       queue_valid;
   logic       queue_ready;
   status_type status;

   rnd_front u_front (
      .character     (req_tdata),
      .end_of_stream (req_tlast),
      .item          (front_item)
   );

   // The queue decouples the input from the decode engine: the engine may pause on a
   // stalled result channel while the input keeps flowing until the queue fills.
   rnd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_item  (queue_item)
   );

   // The decode engine holds the number being built. Digits only update state; a blank,
   // an unknown character or the end of the stream closes the number and emits its value.
   // Sums saturate at the largest value that VALUE_BITS can hold.
   rnd_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item_ready (queue_ready),
      .item       (queue_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_value  (rsp_tdata),
      .rsp_status (status),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tuser = status;

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for roman_numeral_decoder_core: directed table plus random text checked against a decoder model.
`timescale 1ns / 100ps

module tb_top;
   import rnd_pkg::*;

   localparam int VALUE_BITS = 16;
   localparam int SUM_MAX = (1 << VALUE_BITS) - 1;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES = 10;
   localparam int PHASE_CHARS = 460;

   // Face value of each digit, indexed by its rank (M first).
   localparam int DIGIT_WEIGHT [7] = '{1000, 500, 100, 50, 10, 5, 1};
   // Standard Roman parts used to spell well-formed numbers.
   localparam int PART_VALUE [13] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};

   // One decoded number as it shows up on the result channel.
   typedef struct packed {
      logic [15:0] value;
      status_type  status;
      logic        last;
   } decoded_number_type;

   // One row of the directed table. When known is set, the results are typed in here.
   typedef struct packed {
      logic [7:0]  ch;
      logic        eos;
      logic        known;
      logic [1:0]  count;
      logic [15:0] value0;
      status_type  status0;
      logic [15:0] value1;
      status_type  status1;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 25;
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      // End of stream right after reset: nothing to report.
      '{8'h00, 1'b1, 1'b1, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK},
      // Lowest and highest byte values are not Roman digits.
      '{8'h00, 1'b0, 1'b1, 2'd1, 16'd0, STATUS_NOT_ROMAN, 16'd0, STATUS_OK},
      '{8'hFF, 1'b0, 1'b1, 2'd1, 16'd0, STATUS_NOT_ROMAN, 16'd0, STATUS_OK},
      // IXX: the digit after a pair starts fresh. End of stream ignores its byte.
      '{"I",   1'b0, 1'b0, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK},
      '{"X",   1'b0, 1'b0, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK},
      '{"X",   1'b0, 1'b0, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK},
      '{8'hA5, 1'b1, 1'b0, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK},
      // IL is a bad pair; the closing byte then reports the number and not_roman.
      '{"I",   1'b0, 1'b0, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK},
      '{"L",   1'b0, 1'b0, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK},
      '{"?",   1'b0, 1'b1, 2'd2, 16'd0, STATUS_BAD_PAIR, 16'd0, STATUS_NOT_ROMAN},
      // CMXLIX closed by carriage return.
      '{"C",   1'b0, 1'b0, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK},
      '{"M",   1'b0, 1'b0, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK},
      '{"X",   1'b0, 1'b0, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK},
      '{"L",   1'b0, 1'b0, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK},
      '{"I",   1'b0, 1'b0, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK},
      '{"X",   1'b0, 1'b0, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK},
      '{8'h0D, 1'b0, 1'b0, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK},
      // DCD: a falling step followed by a pair, closed by vertical tab.
      '{"D",   1'b0, 1'b0, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK},
      '{"C",   1'b0, 1'b0, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK},
      '{"D",   1'b0, 1'b0, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK},
      '{8'h0B, 1'b0, 1'b0, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK},
      // VX: V may not lead a pair.
      '{"V",   1'b0, 1'b0, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK},
      '{"X",   1'b0, 1'b0, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK},
      '{" ",   1'b0, 1'b1, 2'd1, 16'd0, STATUS_BAD_PAIR, 16'd0, STATUS_OK},
      // A space outside a number is skipped.
      '{" ",   1'b0, 1'b1, 2'd0, 16'd0, STATUS_OK, 16'd0, STATUS_OK}
   };

   string part_text [13] = '{"M", "CM", "D", "CD", "C", "XC", "L", "XL", "X", "IX", "V", "IV", "I"};

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // Model state of the number being decoded.
   logic [2:0]            held_rank = '0;
   logic                  held_valid = 1'b0;
   logic [VALUE_BITS:0]   running_sum = '0;
   logic                  in_number = 1'b0;
   logic                  bad_pair_seen = 1'b0;
   logic                  saturated = 1'b0;

   decoded_number_type pending_numbers [$];
   int error_count = 0;
   int chars_counted = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int quiet_cycles = 0;

   roman_numeral_decoder_core #(
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // character [7:0]
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // number_value [15:0]
      .rsp_tuser  (rsp_tuser),   // status [1:0]
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Returns 1 for an upper case Roman digit and gives its rank.
   function automatic logic digit_rank(input logic [7:0] ch, output logic [2:0] rank);
      rank = RANK_M;
      case (ch)
         "M": rank = RANK_M;
         "D": rank = RANK_D;
         "C": rank = RANK_C;
         "L": rank = RANK_L;
         "X": rank = RANK_X;
         "V": rank = RANK_V;
         "I": rank = RANK_I;
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic logic is_blank(input logic [7:0] ch);
      return ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D);
   endfunction

   // Appends one number to the list of results still to come.
   task automatic expect_number(input decoded_number_type number);
      pending_numbers = {pending_numbers, number};
   endtask

   // Adds to the running sum, pinning it at the maximum once it would overflow.
   task automatic accumulate(input int addend);
      logic [VALUE_BITS:0] total;
      total = running_sum + addend;
      if (total > SUM_MAX) begin
         total = SUM_MAX;
         saturated = 1'b1;
      end
      running_sum = total;
   endtask

   task automatic clear_number();
      held_rank = '0;
      held_valid = 1'b0;
      running_sum = '0;
      in_number = 1'b0;
      bad_pair_seen = 1'b0;
      saturated = 1'b0;
   endtask

   // Advances the model by one character and gives the numbers it closes.
   task automatic decode_char(input logic [7:0] ch, input logic eos,
                              output int count, output decoded_number_type outs [2]);
      logic [2:0] rank;
      logic       is_digit;
      int         gap;
      count = 0;
      outs[0] = '0;
      outs[1] = '0;
      is_digit = digit_rank(ch, rank) && !eos;
      if (is_digit) begin
         if (!in_number) begin
            clear_number();
            in_number = 1'b1;
            held_rank = rank;
            held_valid = 1'b1;
         end else if (!bad_pair_seen) begin
            if (!held_valid) begin
               held_rank = rank;
               held_valid = 1'b1;
            end else if (rank >= held_rank) begin
               accumulate(DIGIT_WEIGHT[held_rank]);
               held_rank = rank;
            end else begin
               // Rising step: only C, X and I may lead, one or two ranks up.
               gap = held_rank - rank;
               if (gap <= 2 && (held_rank == RANK_C || held_rank == RANK_X ||
                                held_rank == RANK_I)) begin
                  accumulate((gap == 1 ? 4 : 9) * DIGIT_WEIGHT[held_rank]);
               end else begin
                  bad_pair_seen = 1'b1;
               end
               held_valid = 1'b0;
            end
         end
         return;
      end
      if (in_number) begin
         if (!bad_pair_seen && held_valid) accumulate(DIGIT_WEIGHT[held_rank]);
         if (bad_pair_seen) begin
            outs[count].value = '0;
            outs[count].status = STATUS_BAD_PAIR;
         end else begin
            outs[count].value = running_sum[15:0];
            outs[count].status = saturated ? STATUS_OVERFLOW : STATUS_OK;
         end
         count++;
         clear_number();
      end
      if (!eos && !is_blank(ch)) begin
         outs[count].value = '0;
         outs[count].status = STATUS_NOT_ROMAN;
         count++;
      end
      if (count > 0) outs[count-1].last = 1'b1;
   endtask

   // Presents one beat, idling first as the current phase asks, and returns at its handshake.
   task automatic drive_beat(input logic [7:0] ch, input logic eos);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ch;
      req_tlast <= eos;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_char(input logic [7:0] ch, input logic eos);
      decoded_number_type outs [2];
      int count;
      logic [2:0] rank;
      drive_beat(ch, eos);
      decode_char(ch, eos, count, outs);
      for (int i = 0; i < count; i++) expect_number(outs[i]);
      // Skipped blanks and idle end markers do not count as work.
      if (count > 0 || (digit_rank(ch, rank) && !eos)) chars_counted++;
   endtask

   // The sender holds off until every number in flight has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_numbers.size() != 0);
   endtask

   function automatic logic [7:0] random_other();
      logic [7:0] ch;
      logic [2:0] rank;
      do ch = 8'($urandom_range(255)); while (digit_rank(ch, rank) || is_blank(ch));
      return ch;
   endfunction

   // One run of text: mostly well-formed numbers, some random digit strings,
   // some long M runs that may overflow, and some raw noise bytes.
   task automatic send_random_number();
      localparam string DIGITS = "MDCLXVI";
      logic [7:0] blanks [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
      int style;
      int value;
      int pick;
      string part;
      style = $urandom_range(99);
      if (style < 45) begin
         value = $urandom_range(3999, 1);
         for (int i = 0; i < 13; i++) begin
            while (value >= PART_VALUE[i]) begin
               part = part_text[i];
               for (int k = 0; k < part.len(); k++) send_char(part[k], 1'b0);
               value -= PART_VALUE[i];
            end
         end
      end else if (style < 80) begin
         repeat ($urandom_range(10, 1)) send_char(DIGITS[$urandom_range(6)], 1'b0);
      end else if (style < 85) begin
         // 66 M's pass the 16 bit maximum; a trailing IC adds a bad pair on top.
         repeat ($urandom_range(72, 60)) send_char("M", 1'b0);
         if ($urandom_range(1)) begin
            send_char("I", 1'b0);
            send_char("C", 1'b0);
         end else begin
            repeat ($urandom_range(3)) send_char(DIGITS[$urandom_range(6)], 1'b0);
         end
      end else begin
         repeat ($urandom_range(4, 1))
            send_char(8'($urandom_range(255)), $urandom_range(7) == 0);
         return;
      end
      pick = $urandom_range(9);
      if (pick < 5) begin
         repeat ($urandom_range(2, 1)) send_char(blanks[$urandom_range(5)], 1'b0);
      end else if (pick < 8) begin
         send_char(random_other(), 1'b0);
      end else begin
         send_char(8'($urandom_range(255)), 1'b1);
      end
   endtask

   // Result side: random back-pressure and a field by field check against the oldest number.
   always @(posedge clock) begin : rsp_check
      decoded_number_type want;
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_numbers.size() == 0) begin
            $error("rsp beat with no number expected: number_value %0d status %0d",
                   rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = pending_numbers.pop_front();
            if (rsp_tdata !== want.value) begin
               $error("number_value: expected %0d, got %0d", want.value, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_of_run: expected %0d, got %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Watchdog: too long without any beat on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("roman_numeral_decoder_core test failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      decoded_number_type outs [2];
      int count;
      int phase_start;
      // Idle percentages per phase: none, sender only, receiver only, both.
      int idle_plan [4] = '{0, 64, 0, 37};
      int stall_plan [4] = '{0, 0, 64, 37};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table, no idling on either side.
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         drive_beat(DIRECTED[r].ch, DIRECTED[r].eos);
         decode_char(DIRECTED[r].ch, DIRECTED[r].eos, count, outs);
         if (DIRECTED[r].known) begin
            // Typed-in results replace the model's for these rows.
            count = DIRECTED[r].count;
            outs[0] = '{DIRECTED[r].value0, DIRECTED[r].status0, count == 1};
            outs[1] = '{DIRECTED[r].value1, DIRECTED[r].status1, 1'b1};
         end
         for (int i = 0; i < count; i++) expect_number(outs[i]);
      end
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_plan[phase];
         rsp_stall_pct = stall_plan[phase];
         phase_start = chars_counted;
         while (chars_counted - phase_start < PHASE_CHARS) send_random_number();
         drain_results();
      end

      // Let any stray result show up before the verdict.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_numbers.size() == 0) begin
         $display("roman_numeral_decoder_core test passed");
      end else begin
         $display("roman_numeral_decoder_core test failed");
      end
      $finish;
   end

endmodule
